@@ sv/capability_task_dispatcher_top_assert.svh @@
// Assertion helpers for the capability task dispatcher.
// Both expect clk_i and rst_ni in scope.
`ifndef CAPABILITY_TASK_DISPATCHER_TOP_ASSERT_SVH
`define CAPABILITY_TASK_DISPATCHER_TOP_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define CTD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen out of reset.
`define CTD_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ sv/ctd_pkg.sv @@
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared sizes, codes and control/status types of the task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ctd_pkg;

  localparam int NumTasks  = 16;
  localparam int NumAgents = 4;
  localparam int LabelBits = 8;
  localparam int RetryBits = 4;
  localparam int TaskW     = $clog2(NumTasks);
  localparam int CountW    = $clog2(NumTasks + 1);
  localparam int FailW     = RetryBits + 1;
  localparam int AgentW    = 2;
  localparam int AcntW     = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 16;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_REQ  = 2'd1;
  localparam logic [1:0] CMD_REP  = 2'd2;

  localparam logic [1:0] AST_PASS = 2'd0;
  localparam logic [1:0] AST_FAIL = 2'd1;
  localparam logic [1:0] AST_TOUT = 2'd2;
  localparam logic [1:0] AST_ERR  = 2'd3;

  localparam logic [2:0] FS_NONE    = 3'd0;
  localparam logic [2:0] FS_PASS    = 3'd1;
  localparam logic [2:0] FS_FAIL    = 3'd2;
  localparam logic [2:0] FS_TOUT    = 3'd3;
  localparam logic [2:0] FS_UNSCHED = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_AGENT_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LABELS0     = 3'd1;

  typedef struct packed {
    logic              granted;
    logic [TaskW-1:0]  task_idx;
    logic [2:0]        status;
    logic              flaky;
    logic              bad;
    logic [CountW-1:0] left;
  } result_t;

  typedef struct packed {
    logic [LabelBits-1:0] needs;
    logic [RetryBits-1:0] limit;
    logic [FailW-1:0]     fails;
    logic [NumAgents-1:0] tried;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic load_exec;
    logic rd_slot;
    logic rep_exec;
    logic scan_start;
    logic scan_step;
    logic hit_exec;
    logic emit_none;
    logic flush;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       req_ok;
    logic       push_ok;
    logic       out_free;
    logic       sweep_go;
    logic       chk_valid;
    logic       chk_hit;
    logic       chk_last;
  } stat_t;

  // Agents that are enabled, alive and hold every needed label.
  function automatic logic [NumAgents-1:0] live_capable(
    input logic [LabelBits-1:0]                 needs,
    input logic [NumAgents-1:0][LabelBits-1:0]  labels,
    input logic [NumAgents-1:0]                 ok
  );
    logic [NumAgents-1:0] r;
    for (int a = 0; a < NumAgents; a++) begin
      r[a] = ok[a] && ((needs & ~labels[a]) == '0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/capability_task_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// capability_task_dispatcher_top
// Task table dispatcher matching tasks to capable, live agents.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word (load, request, report); m_axis returns
//   one or more result words per command, tlast on the final one.
//   cfg_we_i/cfg_idx_i/cfg_data_i write agent count and label masks; write
//   them only while no command is in flight.
// Timing:
//   One command at a time. Load, report and simple commands pass through
//   dispatch, an execute state and the final flush before the next accept.
//   A request walks the 16 entries one per cycle, while no hit is held for
//   output, through the single read port of the task memory. An agent-error
//   report sweeps the table the same way.
//   The last result of a command is staged until the command is known to be
//   finished, then pushed with tlast.
// Reset: table empty, all agents alive, agent count 4, labels 0.
// Stall: a full output register holds the sequencer; no word is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module capability_task_dispatcher_top import ctd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // command, agent_index, task_slot, needs_mask, retry_limit, attempt_status
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // granted, task_index, final_status, flaky, bad_command, tasks_left
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;

  ctd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ctd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`include "capability_task_dispatcher_top_assert.svh"

  `CTD_ASSERT(a_one_cmd, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second command taken while busy")
  `CTD_ASSERT(a_push_ok, (ctrl.load_exec || ctrl.rep_exec || ctrl.hit_exec || ctrl.emit_none) |-> stat.push_ok, "result pushed over a full stage")
  `CTD_ASSERT(a_flush_free, ctrl.flush |-> stat.out_free, "flush into a full output register")
  `CTD_NEVER(a_left_range, m_axis_tvalid && (m_axis_tdata[14:10] > CountW'(NumTasks)), "tasks_left beyond table size")

endmodule

`default_nettype wire

@@ sv/ctd_dp.sv @@
// ----------------------------------------------------------------------------
// ctd_dp
// Task table, agent state, scan pipeline and result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_dp import ctd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctrl_t               ctrl_i,
  output stat_t                    stat_o,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_last_o
);

  // captured word
  logic [1:0]           cmd_q;
  logic [AgentW-1:0]    agent_q;
  logic [TaskW-1:0]     slot_q;
  logic [LabelBits-1:0] needs_q;
  logic [RetryBits-1:0] limit_q;
  logic [1:0]           ast_q;

  logic [AcntW-1:0]                    agent_count_q;
  logic [NumAgents-1:0][LabelBits-1:0] labels_q;

  logic [NumTasks-1:0]  loaded_q, running_q, done_q;
  logic [NumAgents-1:0] alive_q;
  logic [CountW-1:0]    rem_q;

  entry_t mem_q [NumTasks];
  entry_t rd_q;
  logic   mem_we, mem_re;
  logic [TaskW-1:0] mem_raddr;
  entry_t mem_wdata;

  logic [TaskW:0]   idx_q;
  logic             chk_v_q;
  logic [TaskW-1:0] chk_idx_q;

  logic    hold_v_q, out_v_q, out_last_q;
  result_t hold_q, out_q, res_d;
  logic    push;

  logic [NumAgents-1:0] used_mask, cap_vec, agent_bit;
  logic [LabelBits-1:0] needs_sel;
  logic                 agent_ok, cap_self, fresh, pend_c, pend_s;
  logic                 req_hit, swp_hit, chk_hit, out_free, push_ok;
  logic                 load_ok, unsched, rep_bad, rep_finish, sweep_go, over, is_fail;
  logic [FailW-1:0]     fail_inc;
  logic [2:0]           rep_status;
  logic [CountW-1:0]    rem_dec;

  always_comb begin
    for (int a = 0; a < NumAgents; a++) begin
      used_mask[a] = (AcntW'(a) < agent_count_q);
    end
  end

  assign agent_ok  = used_mask[agent_q];
  assign agent_bit = NumAgents'(1) << agent_q;
  assign needs_sel = ctrl_i.load_exec ? needs_q : rd_q.needs;
  assign cap_vec   = live_capable(needs_sel, labels_q, used_mask & alive_q);
  assign cap_self  = (rd_q.needs & ~labels_q[agent_q]) == '0;
  assign fresh     = |(cap_vec & ~rd_q.tried & ~agent_bit);

  assign pend_c  = loaded_q[chk_idx_q] & ~done_q[chk_idx_q];
  assign req_hit = pend_c & ~running_q[chk_idx_q] & cap_self
                 & ~(rd_q.tried[agent_q] & fresh);
  assign swp_hit = pend_c & ~running_q[chk_idx_q] & ~(|cap_vec);
  assign chk_hit = chk_v_q & ((cmd_q == CMD_REQ) ? req_hit : swp_hit);

  assign out_free = !out_v_q || out_ready_i;
  assign push_ok  = !hold_v_q || out_free;
  assign rem_dec  = rem_q - CountW'(rem_q != '0);

  assign pend_s  = loaded_q[slot_q] & ~done_q[slot_q];
  assign load_ok = !pend_s;
  assign unsched = ~(|cap_vec);

  assign rep_bad  = !agent_ok || !pend_s || !running_q[slot_q];
  assign fail_inc = (rd_q.fails == '1) ? rd_q.fails : rd_q.fails + FailW'(1);
  assign over     = fail_inc > {1'b0, rd_q.limit};
  assign is_fail  = (ast_q == AST_FAIL) || (ast_q == AST_TOUT);
  assign rep_finish = !rep_bad && ((ast_q == AST_PASS) || (is_fail && over));
  assign sweep_go = !rep_bad && (ast_q == AST_ERR) && alive_q[agent_q];

  always_comb begin
    case (ast_q)
      AST_PASS: rep_status = FS_PASS;
      AST_FAIL: rep_status = over ? FS_FAIL : FS_NONE;
      AST_TOUT: rep_status = over ? FS_TOUT : FS_NONE;
      default:  rep_status = FS_NONE;
    endcase
  end

  // result of this cycle's push; left carries the count after it
  always_comb begin
    res_d      = '0;
    res_d.left = rem_q;
    if (ctrl_i.load_exec) begin
      res_d.task_idx = slot_q;
      if (load_ok) begin
        res_d.status = unsched ? FS_UNSCHED : FS_NONE;
        res_d.left   = unsched ? rem_q : rem_q + CountW'(1);
      end
    end else if (ctrl_i.rep_exec) begin
      res_d.task_idx = slot_q;
      if (rep_bad) begin
        res_d.bad = 1'b1;
      end else begin
        res_d.status = rep_status;
        res_d.flaky  = (ast_q == AST_PASS) && (rd_q.fails != '0);
        res_d.left   = rep_finish ? rem_dec : rem_q;
      end
    end else if (ctrl_i.hit_exec) begin
      res_d.task_idx = chk_idx_q;
      if (cmd_q == CMD_REQ) begin
        res_d.granted = 1'b1;
      end else begin
        res_d.status = FS_UNSCHED;
        res_d.left   = rem_dec;
      end
    end
  end

  assign push = ctrl_i.load_exec | ctrl_i.rep_exec | ctrl_i.hit_exec | ctrl_i.emit_none;

  // task table memory
  assign mem_we    = (ctrl_i.load_exec && load_ok) || (ctrl_i.rep_exec && !rep_bad);
  assign mem_re    = ctrl_i.rd_slot || (ctrl_i.scan_step && (idx_q < (TaskW+1)'(NumTasks)));
  assign mem_raddr = ctrl_i.rd_slot ? slot_q : idx_q[TaskW-1:0];

  always_comb begin
    if (ctrl_i.load_exec) begin
      mem_wdata = '{needs: needs_q, limit: limit_q, fails: '0, tried: '0};
    end else begin
      mem_wdata = '{needs: rd_q.needs, limit: rd_q.limit,
                    fails: is_fail ? fail_inc : rd_q.fails,
                    tried: rd_q.tried | agent_bit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= in_data_i[1:0];
      agent_q <= in_data_i[3:2];
      slot_q  <= in_data_i[7:4];
      needs_q <= in_data_i[15:8];
      limit_q <= in_data_i[19:16];
      ast_q   <= in_data_i[21:20];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      hold_q <= res_d;
    end
    if ((push && hold_v_q) || ctrl_i.flush) begin
      out_q      <= hold_q;
      out_last_q <= ctrl_i.flush;
    end
    if (ctrl_i.scan_step) begin
      chk_idx_q <= idx_q[TaskW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agent_count_q <= AcntW'(NumAgents);
      labels_q      <= '0;
      loaded_q      <= '0;
      running_q     <= '0;
      done_q        <= '0;
      alive_q       <= '1;
      rem_q         <= '0;
      idx_q         <= '0;
      chk_v_q       <= 1'b0;
      hold_v_q      <= 1'b0;
      out_v_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_AGENT_COUNT) begin
          agent_count_q <= cfg_data_i[AcntW-1:0];
        end else if (cfg_idx_i >= REG_LABELS0 &&
                     cfg_idx_i < REG_LABELS0 + CfgIdxW'(NumAgents)) begin
          labels_q[AgentW'(cfg_idx_i - REG_LABELS0)] <= cfg_data_i[LabelBits-1:0];
        end
      end

      if (push) begin
        rem_q <= res_d.left;
      end

      if (ctrl_i.load_exec && load_ok) begin
        loaded_q[slot_q]  <= 1'b1;
        done_q[slot_q]    <= unsched;
        running_q[slot_q] <= 1'b0;
      end
      if (ctrl_i.rep_exec && !rep_bad) begin
        running_q[slot_q] <= 1'b0;
        if (rep_finish) begin
          done_q[slot_q] <= 1'b1;
        end
        if (sweep_go) begin
          alive_q <= alive_q & ~agent_bit;
        end
      end
      if (ctrl_i.hit_exec) begin
        if (cmd_q == CMD_REQ) begin
          running_q[chk_idx_q] <= 1'b1;
        end else begin
          done_q[chk_idx_q]    <= 1'b1;
          running_q[chk_idx_q] <= 1'b0;
        end
      end

      // scan pipeline: address stage then check stage
      if (ctrl_i.scan_start) begin
        idx_q   <= '0;
        chk_v_q <= 1'b0;
      end else if (ctrl_i.scan_step) begin
        chk_v_q <= idx_q < (TaskW+1)'(NumTasks);
        if (idx_q < (TaskW+1)'(NumTasks)) begin
          idx_q <= idx_q + (TaskW+1)'(1);
        end
      end

      // a push over a held word implies the output register is free
      if ((push && hold_v_q) || ctrl_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (push) begin
        hold_v_q <= 1'b1;
      end else if (ctrl_i.flush) begin
        hold_v_q <= 1'b0;
      end
    end
  end

  assign stat_o = '{cmd: cmd_q, req_ok: agent_ok && alive_q[agent_q], push_ok: push_ok,
                    out_free: out_free, sweep_go: sweep_go, chk_valid: chk_v_q,
                    chk_hit: chk_hit, chk_last: chk_idx_q == TaskW'(NumTasks - 1)};

  assign out_valid_o = out_v_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {1'b0, out_q.left, out_q.bad, out_q.flaky, out_q.status,
                        out_q.task_idx, out_q.granted};

endmodule

`default_nettype wire

@@ sv/ctd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctd_ctrl
// Command sequencer: dispatch, table scan, result push and final flush.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_ctrl import ctd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_REP  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_NONE = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.cmd)
          CMD_LOAD: state_d = S_LOAD;
          CMD_REQ: begin
            if (stat_i.req_ok) begin
              ctrl_o.scan_start = 1'b1;
              state_d           = S_SCAN;
            end else begin
              state_d = S_NONE;
            end
          end
          CMD_REP: begin
            ctrl_o.rd_slot = 1'b1;
            state_d        = S_REP;
          end
          default: state_d = S_NONE;
        endcase
      end
      S_LOAD: begin
        if (stat_i.push_ok) begin
          ctrl_o.load_exec = 1'b1;
          state_d          = S_FIN;
        end
      end
      S_NONE: begin
        if (stat_i.push_ok) begin
          ctrl_o.emit_none = 1'b1;
          state_d          = S_FIN;
        end
      end
      S_REP: begin
        if (stat_i.push_ok) begin
          ctrl_o.rep_exec = 1'b1;
          if (stat_i.sweep_go) begin
            ctrl_o.scan_start = 1'b1;
            state_d           = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.chk_hit) begin
          // hold the pipeline while the staged word cannot move
          if (stat_i.push_ok) begin
            ctrl_o.hit_exec = 1'b1;
            if (stat_i.cmd == CMD_REQ) begin
              state_d = S_FIN;
            end else begin
              ctrl_o.scan_step = 1'b1;
              if (stat_i.chk_last) begin
                state_d = S_FIN;
              end
            end
          end
        end else begin
          ctrl_o.scan_step = 1'b1;
          if (stat_i.chk_valid && stat_i.chk_last) begin
            state_d = (stat_i.cmd == CMD_REQ) ? S_NONE : S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.flush = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
